// ----- rtl/core/polygon_edge_clip_stage_defines.svh -----
// ----------------------------------------------------------------------------
// Polygon edge clip stage assertion macros
// Shared property forms for the checkers of the clip stage.
// ----------------------------------------------------------------------------
`ifndef POLYGON_EDGE_CLIP_STAGE_DEFINES_SVH
`define POLYGON_EDGE_CLIP_STAGE_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled in reset.
`define PECS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("clip stage check failed");

// Next-cycle implication, sampled on aclk and disabled in reset.
`define PECS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("clip stage check failed");

`endif

// ----- rtl/core/pecs_pkg.sv -----
// ----------------------------------------------------------------------------
// Polygon edge clip stage package
// Register map constants of the configuration port.
// ----------------------------------------------------------------------------
package pecs_pkg;

    localparam int ADDR_BITS = 4;

    typedef enum logic [1:0] {
        REG_CLIP_X1 = 2'd0,
        REG_CLIP_Y1 = 2'd1,
        REG_CLIP_X2 = 2'd2,
        REG_CLIP_Y2 = 2'd3
    } reg_index_t;

endpackage

// ----- rtl/core/polygon_edge_clip_stage.sv -----
// ----------------------------------------------------------------------------
// Polygon edge clip stage
// One Sutherland-Hodgman stage that clips polygon edges against one clip edge.
// ----------------------------------------------------------------------------
// Each input transaction on the s_ channel carries one polygon edge; the m_
// channel returns zero, one or two clipped vertices per edge, the last one
// flagged with m_run_last. The polygon's last edge closes with m_polygon_end,
// and an empty last edge yields a marker with m_has_vertex low.
// The clip edge is written through the APB port at byte addresses 0, 4, 8
// and 12 (x1, y1, x2, y2); the user must do so only while no edge is in
// flight, as the block does not enforce it. The accepting edge loads the
// first of four stages that form the cross products and the divisor,
// COORD_BITS + 1 stages each resolve one quotient bit of the crossing point,
// and the result buffer is the last register before m_valid.
// An edge can enter every cycle unless the pipeline holds; an edge with two
// results keeps the result buffer busy until both have been taken.
// All stages share one advance enable: when the last divider stage is full
// and the result buffer cannot take it, the whole pipeline and s_ready hold.
// Reset clears the clip edge to zero and empties the pipeline and buffer.
// ----------------------------------------------------------------------------
module polygon_edge_clip_stage #(
    parameter int COORD_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pecs_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_BITS-1:0]         s_edge_x1,
    input  logic signed [COORD_BITS-1:0]         s_edge_y1,
    input  logic signed [COORD_BITS-1:0]         s_edge_x2,
    input  logic signed [COORD_BITS-1:0]         s_edge_y2,
    input  logic                                 s_final_edge,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [COORD_BITS-1:0]         m_vert_x,
    output logic signed [COORD_BITS-1:0]         m_vert_y,
    output logic                                 m_has_vertex,
    output logic                                 m_run_last,
    output logic                                 m_polygon_end
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int P  = 2 * D;
    localparam int X  = P + 1;
    localparam int DW = X + 1;
    localparam int TW = DW + 2;
    localparam int BW = C + 3;
    localparam logic signed [BW-1:0] CMAX = BW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [BW-1:0] CMIN = -BW'(64'sd1 <<< (C - 1));

    typedef struct packed {
        logic signed [C-1:0] ax;
        logic signed [C-1:0] ay;
        logic signed [C-1:0] bx;
        logic signed [C-1:0] by;
        logic                fin;
    } item_t;

    typedef struct packed {
        item_t               item;
        logic signed [D-1:0] pxa;
        logic signed [D-1:0] pya;
        logic signed [D-1:0] pxb;
        logic signed [D-1:0] pyb;
        logic signed [D-1:0] cdx;
        logic signed [D-1:0] cdy;
    } s1_t;

    typedef struct packed {
        item_t               item;
        logic signed [P-1:0] pa1;
        logic signed [P-1:0] pa2;
        logic signed [P-1:0] pb1;
        logic signed [P-1:0] pb2;
    } s2_t;

    typedef struct packed {
        item_t               item;
        logic signed [X-1:0] ca;
        logic signed [X-1:0] cb;
    } s3_t;

    typedef struct packed {
        logic [D-1:0]  q;
        logic [DW-1:0] r;
    } lane_t;

    typedef struct packed {
        item_t         item;
        logic          ain;
        logic          bin;
        logic          sx;
        logic          sy;
        logic [X-1:0]  num;
        logic [DW-1:0] den;
        logic [D-1:0]  mx;
        logic [D-1:0]  my;
        lane_t         lx;
        lane_t         ly;
    } div_t;

    typedef struct packed {
        logic signed [C-1:0] x;
        logic signed [C-1:0] y;
        logic                hv;
        logic                last;
        logic                pend;
    } res_t;

    function automatic lane_t div_step(lane_t li, logic b, logic [X-1:0] num,
                                       logic [DW-1:0] den);
        logic [TW-1:0] t;
        logic [TW-1:0] d1;
        logic [TW-1:0] d2;
        lane_t         lo;
        t  = {1'b0, li.r, 1'b0} + (b ? TW'(num) : TW'(0));
        d1 = TW'(den);
        d2 = {1'b0, den, 1'b0};
        if (t >= d2) begin
            lo.r = DW'(t - d2);
            lo.q = D'({li.q, 1'b0} + (D + 1)'(2));
        end else if (t >= d1) begin
            lo.r = DW'(t - d1);
            lo.q = D'({li.q, 1'b0} + (D + 1)'(1));
        end else begin
            lo.r = DW'(t);
            lo.q = D'({li.q, 1'b0});
        end
        return lo;
    endfunction

    function automatic logic signed [C-1:0] finish(logic signed [C-1:0] a, logic [D-1:0] q,
                                                   logic rnz, logic neg);
        logic signed [BW-1:0] base;
        logic signed [BW-1:0] qe;
        qe = $signed(BW'(q));
        if (neg) begin
            base = BW'(a) - qe;
            if (rnz && base > 0) begin
                base = base - BW'(1);
            end
        end else begin
            base = BW'(a) + qe;
            if (rnz && base < 0) begin
                base = base + BW'(1);
            end
        end
        if (base > CMAX) begin
            base = CMAX;
        end else if (base < CMIN) begin
            base = CMIN;
        end
        return C'(base);
    endfunction

    logic signed [C-1:0] cfg_x1_reg, cfg_y1_reg, cfg_x2_reg, cfg_y2_reg;

    logic  s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    div_t  s4_reg, s4_next;
    logic  d_v_reg [D];
    div_t  d_reg [D];
    div_t  d_next [D];

    res_t        out0_reg, out1_reg, r0_next, r1_next;
    logic [1:0]  cnt_reg, n_next;
    logic        pop, buf_free, adv;
    logic        cfg_wr;
    logic signed [D-1:0] dx, dy;
    logic signed [C-1:0] ix, iy;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (pecs_pkg::reg_index_t'(paddr[3:2]))
            pecs_pkg::REG_CLIP_X1: prdata = 32'(cfg_x1_reg);
            pecs_pkg::REG_CLIP_Y1: prdata = 32'(cfg_y1_reg);
            pecs_pkg::REG_CLIP_X2: prdata = 32'(cfg_x2_reg);
            pecs_pkg::REG_CLIP_Y2: prdata = 32'(cfg_y2_reg);
            default:               prdata = 32'(0);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_x1_reg <= '0;
            cfg_y1_reg <= '0;
            cfg_x2_reg <= '0;
            cfg_y2_reg <= '0;
        end else if (cfg_wr) begin
            case (pecs_pkg::reg_index_t'(paddr[3:2]))
                pecs_pkg::REG_CLIP_X1: cfg_x1_reg <= C'(pwdata);
                pecs_pkg::REG_CLIP_Y1: cfg_y1_reg <= C'(pwdata);
                pecs_pkg::REG_CLIP_X2: cfg_x2_reg <= C'(pwdata);
                pecs_pkg::REG_CLIP_Y2: cfg_y2_reg <= C'(pwdata);
                default: ;
            endcase
        end
    end

    assign m_valid  = (cnt_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign buf_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign adv      = !d_v_reg[D-1] || buf_free;
    assign s_ready  = adv;

    always_comb begin
        s1_next.item.ax  = s_edge_x1;
        s1_next.item.ay  = s_edge_y1;
        s1_next.item.bx  = s_edge_x2;
        s1_next.item.by  = s_edge_y2;
        s1_next.item.fin = s_final_edge;
        s1_next.pxa = D'(s_edge_x1) - D'(cfg_x1_reg);
        s1_next.pya = D'(s_edge_y1) - D'(cfg_y1_reg);
        s1_next.pxb = D'(s_edge_x2) - D'(cfg_x1_reg);
        s1_next.pyb = D'(s_edge_y2) - D'(cfg_y1_reg);
        s1_next.cdx = D'(cfg_x2_reg) - D'(cfg_x1_reg);
        s1_next.cdy = D'(cfg_y2_reg) - D'(cfg_y1_reg);

        s2_next.item = s1_reg.item;
        s2_next.pa1  = P'(s1_reg.cdx) * P'(s1_reg.pya);
        s2_next.pa2  = P'(s1_reg.cdy) * P'(s1_reg.pxa);
        s2_next.pb1  = P'(s1_reg.cdx) * P'(s1_reg.pyb);
        s2_next.pb2  = P'(s1_reg.cdy) * P'(s1_reg.pxb);

        s3_next.item = s2_reg.item;
        s3_next.ca   = X'(s2_reg.pa1) - X'(s2_reg.pa2);
        s3_next.cb   = X'(s2_reg.pb1) - X'(s2_reg.pb2);

        dx = D'(s3_reg.item.bx) - D'(s3_reg.item.ax);
        dy = D'(s3_reg.item.by) - D'(s3_reg.item.ay);
        s4_next.item = s3_reg.item;
        s4_next.ain  = s3_reg.ca < 0;
        s4_next.bin  = s3_reg.cb < 0;
        s4_next.sx   = dx < 0;
        s4_next.sy   = dy < 0;
        s4_next.num  = (s3_reg.ca < 0) ? X'(-s3_reg.ca) : X'(s3_reg.ca);
        s4_next.den  = ((s3_reg.ca < 0) ? DW'($unsigned(X'(-s3_reg.ca)))
                                        : DW'($unsigned(s3_reg.ca)))
                     + ((s3_reg.cb < 0) ? DW'($unsigned(X'(-s3_reg.cb)))
                                        : DW'($unsigned(s3_reg.cb)));
        s4_next.mx   = (dx < 0) ? D'(-dx) : D'(dx);
        s4_next.my   = (dy < 0) ? D'(-dy) : D'(dy);
        s4_next.lx   = '0;
        s4_next.ly   = '0;
    end

    always_comb begin
        for (int k = 0; k < D; k++) begin
            d_next[k] = (k == 0) ? s4_reg : d_reg[(k == 0) ? 0 : k - 1];
            d_next[k].lx = div_step(d_next[k].lx, d_next[k].mx[D-1-k],
                                    d_next[k].num, d_next[k].den);
            d_next[k].ly = div_step(d_next[k].ly, d_next[k].my[D-1-k],
                                    d_next[k].num, d_next[k].den);
        end
    end

    always_comb begin
        ix = finish(d_reg[D-1].item.ax, d_reg[D-1].lx.q, d_reg[D-1].lx.r != '0,
                    d_reg[D-1].sx);
        iy = finish(d_reg[D-1].item.ay, d_reg[D-1].ly.q, d_reg[D-1].ly.r != '0,
                    d_reg[D-1].sy);
        r0_next = '0;
        r1_next = '0;
        n_next  = 2'd0;
        if (d_reg[D-1].ain != d_reg[D-1].bin) begin
            r0_next.x  = ix;
            r0_next.y  = iy;
            r0_next.hv = 1'b1;
            if (d_reg[D-1].bin) begin
                r1_next.x    = d_reg[D-1].item.bx;
                r1_next.y    = d_reg[D-1].item.by;
                r1_next.hv   = 1'b1;
                r1_next.last = 1'b1;
                r1_next.pend = d_reg[D-1].item.fin;
                n_next = 2'd2;
            end else begin
                r0_next.last = 1'b1;
                r0_next.pend = d_reg[D-1].item.fin;
                n_next = 2'd1;
            end
        end else if (d_reg[D-1].bin) begin
            r0_next.x    = d_reg[D-1].item.bx;
            r0_next.y    = d_reg[D-1].item.by;
            r0_next.hv   = 1'b1;
            r0_next.last = 1'b1;
            r0_next.pend = d_reg[D-1].item.fin;
            n_next = 2'd1;
        end else if (d_reg[D-1].item.fin) begin
            r0_next.last = 1'b1;
            r0_next.pend = 1'b1;
            n_next = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            for (int k = 0; k < D; k++) begin
                d_v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            s1_v_reg <= s_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            d_v_reg[0] <= s4_v_reg;
            for (int k = 1; k < D; k++) begin
                d_v_reg[k] <= d_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            for (int k = 0; k < D; k++) begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (adv && d_v_reg[D-1]) begin
            cnt_reg <= n_next;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && d_v_reg[D-1]) begin
            out0_reg <= r0_next;
            out1_reg <= r1_next;
        end else if (pop && cnt_reg == 2'd2) begin
            out0_reg <= out1_reg;
        end
    end

    assign m_vert_x      = out0_reg.x;
    assign m_vert_y      = out0_reg.y;
    assign m_has_vertex  = out0_reg.hv;
    assign m_run_last    = out0_reg.last;
    assign m_polygon_end = out0_reg.pend;

endmodule

// ----- rtl/core/pecs_checker.sv -----
// ----------------------------------------------------------------------------
// Polygon edge clip stage checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "polygon_edge_clip_stage_defines.svh"

module pecs_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [COORD_BITS-1:0]          m_vert_x,
    input logic [COORD_BITS-1:0]          m_vert_y,
    input logic                           m_has_vertex,
    input logic                           m_run_last,
    input logic                           m_polygon_end
);

    `PECS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_vert_x) && $stable(m_vert_y) && $stable(m_run_last))

    `PECS_ASSERT_IMPLY(a_marker_closes, m_valid && !m_has_vertex, m_run_last && m_polygon_end)

    `PECS_ASSERT_IMPLY(a_end_is_last, m_valid && m_polygon_end, m_run_last)

    `PECS_ASSERT_NEXT(a_pair_follows, m_valid && m_ready && !m_run_last, m_valid && m_has_vertex)

endmodule

bind polygon_edge_clip_stage pecs_checker #(.COORD_BITS(COORD_BITS)) u_pecs_checker (.*);

// ----- test/tb_polygon_edge_clip_stage.sv -----
// ----------------------------------------------------------------------------
// Polygon edge clip stage testbench
// Sends polygon edges against several clip edges, predicts the clipped
// vertices and end markers, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_polygon_edge_clip_stage;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int AW = pecs_pkg::ADDR_BITS;
    localparam int LATENCY = CB + 6;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic signed [CB-1:0] x1, y1, x2, y2;
        logic                 fin;
    } poly_edge_t;

    typedef struct {
        logic signed [CB-1:0] x, y;
        logic                 hv, rl, pe;
    } clip_vertex_t;

    logic aclk, aresetn;
    logic psel, penable, pwrite;
    logic [AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready, s_final_edge;
    logic signed [CB-1:0] s_edge_x1, s_edge_y1, s_edge_x2, s_edge_y2;
    logic m_valid, m_ready, m_has_vertex, m_run_last, m_polygon_end;
    logic signed [CB-1:0] m_vert_x, m_vert_y;

    polygon_edge_clip_stage #(.COORD_BITS(CB)) dut (.*);

    longint clip_x1, clip_y1, clip_x2, clip_y2;
    clip_vertex_t expected_vertices[$];
    int fails, edges_sent, vertices_seen, markers_seen, burst_left, idle_cycles;
    bit hold_req;
    int hold_left, stall_phase;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        fails++;
    endtask

    function automatic longint cross_at(input longint px, input longint py);
        return (clip_x2 - clip_x1) * (py - clip_y1) - (clip_y2 - clip_y1) * (px - clip_x1);
    endfunction

    function automatic longint crossing(input longint a, input longint b,
                                       input longint num, input longint den);
        longint d, m, prod, q, r, v;
        d = b - a;
        m = d < 0 ? -d : d;
        if (den == 0) return a;
        prod = m * num;
        q = prod / den;
        r = prod % den;
        if (d >= 0) begin
            v = a + q;
            if (r != 0 && v < 0) v++;
        end else begin
            v = a - q;
            if (r != 0 && v > 0) v--;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic void predict_clip(input poly_edge_t e);
        clip_vertex_t res[$];
        clip_vertex_t v;
        longint ca, cb, na, nb;
        ca = cross_at(e.x1, e.y1);
        cb = cross_at(e.x2, e.y2);
        if ((ca < 0) != (cb < 0)) begin
            na = ca < 0 ? -ca : ca;
            nb = cb < 0 ? -cb : cb;
            v.x = CB'(crossing(e.x1, e.x2, na, na + nb));
            v.y = CB'(crossing(e.y1, e.y2, na, na + nb));
            v.hv = 1;
            v.rl = 0;
            v.pe = 0;
            res.insert(res.size(), v);
        end
        if (cb < 0) begin
            v.x = e.x2;
            v.y = e.y2;
            v.hv = 1;
            v.rl = 0;
            v.pe = 0;
            res.insert(res.size(), v);
        end
        if (res.size() == 0 && e.fin) begin
            v.x = 0;
            v.y = 0;
            v.hv = 0;
            v.rl = 0;
            v.pe = 0;
            res.insert(res.size(), v);
        end
        if (res.size() > 0) begin
            res[res.size()-1].rl = 1;
            res[res.size()-1].pe = e.fin;
        end
        foreach (res[i]) expected_vertices.insert(expected_vertices.size(), res[i]);
    endfunction

    always @(posedge aclk) begin
        poly_edge_t e;
        clip_vertex_t want;
        if (aresetn && s_valid && s_ready) begin
            e.x1 = s_edge_x1;
            e.y1 = s_edge_y1;
            e.x2 = s_edge_x2;
            e.y2 = s_edge_y2;
            e.fin = s_final_edge;
            predict_clip(e);
            edges_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_vertices.size() == 0) begin
                $display("result transaction with nothing expected");
                fails++;
            end else begin
                want = expected_vertices.pop_front();
                if (m_vert_x !== want.x) report_mismatch("vert_x", m_vert_x, want.x);
                if (m_vert_y !== want.y) report_mismatch("vert_y", m_vert_y, want.y);
                if (m_has_vertex !== want.hv)
                    report_mismatch("has_vertex", m_has_vertex, want.hv);
                if (m_run_last !== want.rl) report_mismatch("run_last", m_run_last, want.rl);
                if (m_polygon_end !== want.pe)
                    report_mismatch("polygon_end", m_polygon_end, want.pe);
                if (want.hv) vertices_seen++;
                else markers_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("polygon_edge_clip_stage test failed");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        stall_phase++;
        if (hold_req) begin
            hold_req = 0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 0;
        end else begin
            case ((stall_phase / 97) % 3)
                0: m_ready = 1;
                1: m_ready = $urandom_range(0, 1);
                default: m_ready = (stall_phase % 3) != 0;
            endcase
        end
    end

    task automatic apb_write(input pecs_pkg::reg_index_t idx, input longint value);
        @(negedge aclk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = AW'(4 * int'(idx));
        pwdata = {16'($urandom_range(0, 16'hffff)), value[15:0]};
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        case (idx)
            pecs_pkg::REG_CLIP_X1: clip_x1 = longint'($signed(value[15:0]));
            pecs_pkg::REG_CLIP_Y1: clip_y1 = longint'($signed(value[15:0]));
            pecs_pkg::REG_CLIP_X2: clip_x2 = longint'($signed(value[15:0]));
            pecs_pkg::REG_CLIP_Y2: clip_y2 = longint'($signed(value[15:0]));
            default: ;
        endcase
        @(negedge aclk);
        psel = 0;
        penable = 0;
    endtask

    task automatic set_clip(input longint x1, input longint y1,
                            input longint x2, input longint y2);
        apb_write(pecs_pkg::REG_CLIP_X1, x1);
        apb_write(pecs_pkg::REG_CLIP_Y1, y1);
        apb_write(pecs_pkg::REG_CLIP_X2, x2);
        apb_write(pecs_pkg::REG_CLIP_Y2, y2);
    endtask

    task automatic send_edge(input longint x1, input longint y1, input longint x2,
                             input longint y2, input bit fin);
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid = 0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1;
        s_edge_x1 = x1[15:0];
        s_edge_y1 = y1[15:0];
        s_edge_x2 = x2[15:0];
        s_edge_y2 = y2[15:0];
        s_final_edge = fin;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 0;
        while (expected_vertices.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);
    endtask

    function automatic longint rand_coord(input bit wide);
        if (wide) return longint'($signed(16'($urandom)));
        return longint'($urandom_range(0, 400)) - 200;
    endfunction

    task automatic send_polygon(input bit wide);
        longint px[8], py[8];
        int n;
        n = $urandom_range(3, 8);
        for (int i = 0; i < n; i++) begin
            px[i] = rand_coord(wide);
            py[i] = rand_coord(wide);
        end
        for (int i = 0; i < n; i++)
            send_edge(px[i], py[i], px[(i+1)%n], py[(i+1)%n], i == n - 1);
    endtask

    task automatic random_clip();
        bit wide;
        wide = $urandom_range(0, 2) == 0;
        set_clip(rand_coord(wide), rand_coord(wide), rand_coord(wide), rand_coord(wide));
    endtask

    task automatic test_degenerate_clip();
        send_edge(-5, -5, 5, 5, 0);
        send_edge(5, 5, -5, -5, 1);
        wait_idle();
    endtask

    task automatic test_transitions();
        set_clip(0, 0, 100, 0);
        send_edge(10, -10, 20, -20, 0);
        send_edge(10, 10, 20, -30, 0);
        send_edge(-7, -9, 13, 21, 0);
        send_edge(1, 5, 9, 7, 0);
        send_edge(3, 0, 4, 0, 0);
        send_edge(1, 5, 9, 7, 1);
        send_edge(10, 10, 20, -30, 1);
        send_edge(-7, -9, 13, 21, 1);
        wait_idle();
    endtask

    task automatic test_extremes();
        set_clip(-32768, -32768, 32767, 32767);
        send_edge(-32768, 32767, 32767, -32768, 0);
        send_edge(32767, -32768, -32768, 32767, 1);
        send_edge(-32768, -32768, 32767, 32767, 1);
        send_edge(32767, 32767, -32768, -32768, 0);
        wait_idle();
        set_clip(32767, -32768, -32768, 32767);
        send_edge(-32768, -32768, 32767, 32767, 0);
        send_edge(32767, 32767, -32768, -32768, 1);
        send_edge(0, 0, -1, -1, 1);
        wait_idle();
    endtask

    task automatic test_random_polygons(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 10 == 0) begin
                wait_idle();
                random_clip();
            end
            send_polygon($urandom_range(0, 3) == 0);
        end
        wait_idle();
    endtask

    task automatic test_noise_edges(input int count);
        random_clip();
        for (int i = 0; i < count; i++)
            send_edge(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1),
                      $urandom_range(0, 1));
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_clip(-100, 50, 100, -50);
        @(posedge aclk);
        hold_req = 1;
        for (int i = 0; i < 10; i++) send_polygon(0);
        wait_idle();
    endtask

    initial begin
        aresetn = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        s_valid = 0;
        s_edge_x1 = '0;
        s_edge_y1 = '0;
        s_edge_x2 = '0;
        s_edge_y2 = '0;
        s_final_edge = 0;
        m_ready = 0;
        clip_x1 = 0;
        clip_y1 = 0;
        clip_x2 = 0;
        clip_y2 = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        test_degenerate_clip();
        test_transitions();
        test_extremes();
        test_random_polygons(60);
        test_backpressure();
        test_noise_edges(140);
        wait_idle();

        $display("Covered %0d edges over degenerate, extreme and random clip edges.",
                 edges_sent);
        $display("Checked %0d vertices and %0d end markers, with a long receiver hold-off.",
                 vertices_seen, markers_seen);
        if (fails == 0) begin
            $display("polygon_edge_clip_stage test passed");
        end else begin
            $display("polygon_edge_clip_stage test failed");
        end
        $finish;
    end
endmodule
